### sv/nnsc_pkg.sv
// Shared widths, register indexes, pixel modes and pixel widening for the scaler.
package nnsc_pkg;

	localparam int SRC_W = 11;
	localparam int DIM_W = 12;
	localparam int MODE_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int LA_W = 17;
	localparam int PIX_W = 32;
	localparam int XY_W = 11;

	localparam int STORE_DEPTH_DEF = 131072;
	localparam int MAX_DEST_DIM_DEF = 2048;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_STRIDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 3'd5;

	localparam logic [MODE_W-1:0] MODE_RGB565 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RGBX4444 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PASS32 = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	localparam logic [SRC_W-1:0] SRC_WIDTH_RST = 11'd320;
	localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = 11'd240;
	localparam logic [SRC_W-1:0] SRC_STRIDE_RST = 11'd320;
	localparam logic [DIM_W-1:0] DST_WIDTH_RST = 12'd320;
	localparam logic [DIM_W-1:0] DST_HEIGHT_RST = 12'd240;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// replicate the top bits of each channel into the low bits
	function automatic logic [PIX_W-1:0] widen_565(input logic [15:0] p);
		return {ALPHA_OPAQUE, p[15:11], p[15:13], p[10:5], p[10:9], p[4:0], p[4:2]};
	endfunction

	// low nibble is padding and is dropped
	function automatic logic [PIX_W-1:0] widen_4444(input logic [15:0] p);
		return {ALPHA_OPAQUE, p[15:12], p[15:12], p[11:8], p[11:8], p[7:4], p[7:4]};
	endfunction

endpackage

### sv/nearest_neighbor_scaler_pixel_convert_top.sv
// Nearest-neighbor scaler: frame store, bit-serial source coordinate divider, pixel widening.
// Load request: written to the frame store at acceptance, one load per cycle while no emit is in progress.
// Emit request: accepted in idle, then multiply, divide, product, sum, read and form states; the
// source column and line come from one-bit-per-cycle restoring dividers. No new request is taken
// until the result is formed. The output register holds a result while the next request is taken.
// Reset sets counters, state, out_valid and config registers to defaults; datapath and frame store are not cleared.
module nearest_neighbor_scaler_pixel_convert_top
	import nnsc_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int MAX_DEST_DIM = MAX_DEST_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [LA_W-1:0]       load_address,
	input  logic [PIX_W-1:0]      load_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel,
	output logic [XY_W-1:0]       out_x,
	output logic [XY_W-1:0]       out_y,
	output logic                  frame_end,
	output logic                  out_of_range
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(MAX_DEST_DIM);
	localparam int DVD_W = SRC_W + CNT_W;
	localparam int IT_W = $clog2(DVD_W);
	localparam int AS_W = SRC_W + DVD_W + 1;
	localparam int CMP_W = CNT_W + DIM_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_PROD = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_READ = 7'b0100000,
		ST_FORM = 7'b1000000
	} state_t;

	state_t state_q;

	logic [SRC_W-1:0]  source_width_q, source_height_q, source_stride_q;
	logic [DIM_W-1:0]  dest_width_q, dest_height_q;
	logic [MODE_W-1:0] pixel_mode_q;

	logic [CNT_W-1:0] col_cnt_q, line_cnt_q;
	logic [CNT_W-1:0] x_q, y_q;
	logic             eof_q;

	logic [DVD_W-1:0] dvd_x_q, dvd_y_q;
	logic [DIM_W-1:0] rem_x_q, rem_y_q;
	logic [IT_W-1:0]  iter_q;
	logic [AS_W-1:0]  prod_q;
	logic [AW-1:0]    rd_addr_q;
	logic             oor_q;
	logic [PIX_W-1:0] rd_data_q;

	logic [PIX_W-1:0] pixel_q;
	logic [XY_W-1:0]  out_x_q, out_y_q;
	logic             frame_end_q, out_of_range_q, out_valid_q;

	logic [PIX_W-1:0] mem [STORE_DEPTH];

	logic [DIM_W-1:0]      dw_eff, dh_eff;
	logic                  accept, emit_acc, load_we, eol, eof;
	logic [LA_W+AW-1:0]    la_ext;
	logic [AW-1:0]         load_idx;
	logic [DIM_W:0]        rx_sh, ry_sh, rx_sub, ry_sub;
	logic                  rx_ge, ry_ge;
	logic [SRC_W-1:0]      stride;
	logic [AS_W-1:0]       addr_sum;
	logic                  form_fire;
	logic [PIX_W-1:0]      pix_conv;
	logic [CNT_W+XY_W-1:0] x_ext, y_ext;

	always_comb begin
		if (dest_width_q == '0) begin
			dw_eff = DIM_W'(1);
		end else if (32'(dest_width_q) > MAX_DEST_DIM) begin
			dw_eff = DIM_W'(MAX_DEST_DIM);
		end else begin
			dw_eff = dest_width_q;
		end
		if (dest_height_q == '0) begin
			dh_eff = DIM_W'(1);
		end else if (32'(dest_height_q) > MAX_DEST_DIM) begin
			dh_eff = DIM_W'(MAX_DEST_DIM);
		end else begin
			dh_eff = dest_height_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign emit_acc = accept && (command == CMD_EMIT);

	assign la_ext = {{AW{1'b0}}, load_address};
	assign load_idx = la_ext[AW-1:0];
	assign load_we = accept && (command == CMD_LOAD) && (la_ext < (LA_W+AW)'(STORE_DEPTH));

	// a column at or past the last one ends the line, likewise for lines
	assign eol = (CMP_W'(col_cnt_q) + CMP_W'(1)) >= CMP_W'(dw_eff);
	assign eof = eol && ((CMP_W'(line_cnt_q) + CMP_W'(1)) >= CMP_W'(dh_eff));

	// restoring division step, both coordinates in parallel
	assign rx_sh = {rem_x_q, dvd_x_q[DVD_W-1]};
	assign ry_sh = {rem_y_q, dvd_y_q[DVD_W-1]};
	assign rx_ge = rx_sh >= {1'b0, dw_eff};
	assign ry_ge = ry_sh >= {1'b0, dh_eff};
	assign rx_sub = rx_sh - {1'b0, dw_eff};
	assign ry_sub = ry_sh - {1'b0, dh_eff};

	assign stride = (pixel_mode_q == MODE_RGBX4444) ? source_width_q : source_stride_q;
	assign addr_sum = prod_q + AS_W'(dvd_x_q);

	assign form_fire = (state_q == ST_FORM) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (pixel_mode_q)
			MODE_RGB565:   pix_conv = widen_565(rd_data_q[15:0]);
			MODE_RGBX4444: pix_conv = widen_4444(rd_data_q[15:0]);
			default:       pix_conv = rd_data_q;
		endcase
	end

	assign x_ext = {{XY_W{1'b0}}, x_q};
	assign y_ext = {{XY_W{1'b0}}, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q <= SRC_WIDTH_RST;
			source_height_q <= SRC_HEIGHT_RST;
			source_stride_q <= SRC_STRIDE_RST;
			dest_width_q <= DST_WIDTH_RST;
			dest_height_q <= DST_HEIGHT_RST;
			pixel_mode_q <= MODE_RGB565;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH:  source_width_q <= cfg_data[SRC_W-1:0];
				CFG_SRC_HEIGHT: source_height_q <= cfg_data[SRC_W-1:0];
				CFG_SRC_STRIDE: source_stride_q <= cfg_data[SRC_W-1:0];
				CFG_DST_WIDTH:  dest_width_q <= cfg_data[DIM_W-1:0];
				CFG_DST_HEIGHT: dest_height_q <= cfg_data[DIM_W-1:0];
				CFG_PIXEL_MODE: pixel_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_cnt_q <= '0;
			line_cnt_q <= '0;
			iter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (form_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (emit_acc) begin
						state_q <= ST_MUL;
						if (eol) begin
							col_cnt_q <= '0;
							line_cnt_q <= eof ? '0 : line_cnt_q + CNT_W'(1);
						end else begin
							col_cnt_q <= col_cnt_q + CNT_W'(1);
						end
					end
				end
				ST_MUL: begin
					iter_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					iter_q <= iter_q + IT_W'(1);
					if (iter_q == IT_W'(DVD_W - 1)) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_READ;
				ST_READ: state_q <= ST_FORM;
				ST_FORM: begin
					if (form_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, sequenced by the state machine
	always_ff @(posedge clk) begin
		if (emit_acc) begin
			x_q <= col_cnt_q;
			y_q <= line_cnt_q;
			eof_q <= eof;
		end
		if (state_q == ST_MUL) begin
			dvd_x_q <= DVD_W'(source_width_q) * DVD_W'(x_q);
			dvd_y_q <= DVD_W'(source_height_q) * DVD_W'(y_q);
			rem_x_q <= '0;
			rem_y_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_x_q <= rx_ge ? rx_sub[DIM_W-1:0] : rx_sh[DIM_W-1:0];
			rem_y_q <= ry_ge ? ry_sub[DIM_W-1:0] : ry_sh[DIM_W-1:0];
			dvd_x_q <= {dvd_x_q[DVD_W-2:0], rx_ge};
			dvd_y_q <= {dvd_y_q[DVD_W-2:0], ry_ge};
		end
		if (state_q == ST_PROD) begin
			prod_q <= AS_W'(stride) * AS_W'(dvd_y_q);
		end
		if (state_q == ST_SUM) begin
			rd_addr_q <= addr_sum[AW-1:0];
			oor_q <= addr_sum >= AS_W'(STORE_DEPTH);
		end
		if (form_fire) begin
			pixel_q <= oor_q ? '0 : pix_conv;
			out_x_q <= x_ext[XY_W-1:0];
			out_y_q <= y_ext[XY_W-1:0];
			frame_end_q <= eof_q;
			out_of_range_q <= oor_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[load_idx] <= load_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr_q];
	end

	assign out_valid = out_valid_q;
	assign pixel = pixel_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign frame_end = frame_end_q;
	assign out_of_range = out_of_range_q;

endmodule

### sv/nnsc_checker.sv
// Port-level checks for the scaler, bound to the top level.
module nnsc_checker
	import nnsc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             command,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] pixel,
	input logic             out_of_range
);

	// stalled result must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel))
		else $error("result changed while stalled");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> pixel == '0)
		else $error("out of range result carries nonzero pixel");

	// an emit request makes the block busy and drops in_ready
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_EMIT |=> !in_ready)
		else $error("request taken right after an emit");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid after reset");

endmodule

bind nearest_neighbor_scaler_pixel_convert_top nnsc_checker u_nnsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.command      (command),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pixel        (pixel),
	.out_of_range (out_of_range)
);

### bench/tb_top.sv
// Self-checking bench for the nearest-neighbor scaler: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
	import nnsc_pkg::*;

	localparam int ITEM_TARGET = 1000;
	localparam int SETTLE_CYCLES = 48;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EMIT} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [31:0]  where;
		logic [31:0]  value;
		logic         typed;
		logic [31:0]  pix;
		logic         fe;
		logic         oor;
	} directed_row_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [XY_W-1:0]  x;
		logic [XY_W-1:0]  y;
		logic             frame_end;
		logic             oor;
	} scaled_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  command = CMD_LOAD;
	logic [LA_W-1:0]       load_address = '0;
	logic [PIX_W-1:0]      load_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      pixel;
	logic [XY_W-1:0]       out_x;
	logic [XY_W-1:0]       out_y;
	logic                  frame_end;
	logic                  out_of_range;

	nearest_neighbor_scaler_pixel_convert_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.load_address(load_address),
		.load_data(load_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel(pixel),
		.out_x(out_x),
		.out_y(out_y),
		.frame_end(frame_end),
		.out_of_range(out_of_range)
	);

	always #6 clk = ~clk;

	// scaler state as the bench sees it
	logic [SRC_W-1:0]  src_w = SRC_WIDTH_RST;
	logic [SRC_W-1:0]  src_h = SRC_HEIGHT_RST;
	logic [SRC_W-1:0]  src_stride = SRC_STRIDE_RST;
	logic [DIM_W-1:0]  dst_w = DST_WIDTH_RST;
	logic [DIM_W-1:0]  dst_h = DST_HEIGHT_RST;
	logic [MODE_W-1:0] pix_mode = MODE_RGB565;
	int unsigned       col_cnt = 0;
	int unsigned       line_cnt = 0;
	bit [31:0]         src_store [int unsigned];

	scaled_pixel_t     pending_pixels [$];
	scaled_pixel_t     head_pixel;
	int unsigned       mismatches = 0;
	int unsigned       items_sent = 0;
	int unsigned       stall_cycles = 0;
	bit                hold_request = 1'b0;

	directed_row_t plan [0:36] = '{
		'{ROW_LOAD, 0, 32'h0000_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_LOAD, 1, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'hFF00_0000, 1'b0, 1'b0},
		'{ROW_CFG, CFG_DST_WIDTH, 1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_DST_HEIGHT, 1, 1'b0, 32'h0, 1'b0, 1'b0},
		// column counter is now past the shrunk frame
		'{ROW_LOAD, 640, 32'hFFFF_0000, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'hFF00_0000, 1'b1, 1'b0},
		'{ROW_CFG, CFG_PIXEL_MODE, MODE_RGBX4444, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{ROW_LOAD, 0, 32'h1234_A5C3, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'hFFAA_55CC, 1'b1, 1'b0},
		'{ROW_CFG, CFG_PIXEL_MODE, MODE_PASS32, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'h1234_A5C3, 1'b1, 1'b0},
		'{ROW_CFG, CFG_PIXEL_MODE, MODE_UNDEF, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'h1234_A5C3, 1'b1, 1'b0},
		'{ROW_CFG, CFG_DST_HEIGHT, 2, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_HEIGHT, 2047, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_STRIDE, 2047, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b1, 32'h1234_A5C3, 1'b0, 1'b0},
		// second line lands far beyond the store
		'{ROW_EMIT, 0, 0, 1'b1, 32'h0000_0000, 1'b1, 1'b1},
		'{ROW_LOAD, 131071, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_DST_WIDTH, 0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_DST_HEIGHT, 4095, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_WIDTH, 0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_HEIGHT, 0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_STRIDE, 0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_PIXEL_MODE, MODE_RGB565, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_DST_WIDTH, 2048, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_WIDTH, 1024, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_STRIDE, 1024, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_SRC_HEIGHT, 1024, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_CFG, CFG_DST_HEIGHT, 2048, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_EMIT, 0, 0, 1'b0, 32'h0, 1'b0, 1'b0}
	};

	function automatic int unsigned dest_span(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DEST_DIM_DEF)
			return MAX_DEST_DIM_DEF;
		return v;
	endfunction

	function automatic longint unsigned source_address();
		longint unsigned sx, sy, pitch;
		sx = src_w;
		sx = sx * col_cnt / dest_span(dst_w);
		sy = src_h;
		sy = sy * line_cnt / dest_span(dst_h);
		pitch = (pix_mode == MODE_RGBX4444) ? src_w : src_stride;
		return pitch * sy + sx;
	endfunction

	// scale an n-bit channel to 8 bits by repeating its top bits
	function automatic logic [7:0] expand_bits(input int unsigned v, input int unsigned n);
		int unsigned w;
		w = (v << (8 - n)) | (v >> (2 * n - 8));
		return w[7:0];
	endfunction

	function automatic logic [PIX_W-1:0] widen_pixel(input logic [31:0] raw);
		case (pix_mode)
			MODE_RGB565: return {ALPHA_OPAQUE, expand_bits(raw[15:11], 5),
				expand_bits(raw[10:5], 6), expand_bits(raw[4:0], 5)};
			MODE_RGBX4444: return {ALPHA_OPAQUE, expand_bits(raw[15:12], 4),
				expand_bits(raw[11:8], 4), expand_bits(raw[7:4], 4)};
			default: return raw;
		endcase
	endfunction

	// produce the next raster pixel and step the counters
	function automatic scaled_pixel_t advance_raster();
		scaled_pixel_t r;
		longint unsigned a;
		int unsigned dw, dh;
		bit eol, eof;
		a = source_address();
		dw = dest_span(dst_w);
		dh = dest_span(dst_h);
		r.oor = (a >= STORE_DEPTH_DEF);
		r.pixel = '0;
		if (!r.oor)
			r.pixel = widen_pixel(src_store.exists(a) ? src_store[a] : 32'h0);
		eol = (col_cnt + 1 >= dw);
		eof = eol && (line_cnt + 1 >= dh);
		r.x = col_cnt[XY_W-1:0];
		r.y = line_cnt[XY_W-1:0];
		r.frame_end = eof;
		if (eol) begin
			col_cnt = 0;
			line_cnt = eof ? 0 : line_cnt + 1;
		end else begin
			col_cnt = col_cnt + 1;
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 150);
	endfunction

	function automatic int unsigned pick_corner(input int unsigned a, input int unsigned b,
		input int unsigned c, input int unsigned d);
		case ($urandom_range(0, 3))
			0: return a;
			1: return b;
			2: return c;
			default: return d;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SRC_WIDTH: src_w = val[SRC_W-1:0];
			CFG_SRC_HEIGHT: src_h = val[SRC_W-1:0];
			CFG_SRC_STRIDE: src_stride = val[SRC_W-1:0];
			CFG_DST_WIDTH: dst_w = val[DIM_W-1:0];
			CFG_DST_HEIGHT: dst_h = val[DIM_W-1:0];
			CFG_PIXEL_MODE: pix_mode = val[MODE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_request(input logic cmd, input logic [LA_W-1:0] addr,
		input logic [PIX_W-1:0] data, input bit typed, input logic [PIX_W-1:0] t_pix,
		input logic t_fe, input logic t_oor);
		scaled_pixel_t want;
		in_valid <= 1'b1;
		command <= cmd;
		load_address <= addr;
		load_data <= data;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (cmd == CMD_LOAD) begin
			src_store[addr] = data;
		end else begin
			want = advance_raster();
			if (typed) begin
				want.pixel = t_pix;
				want.frame_end = t_fe;
				want.oor = t_oor;
			end
			pending_pixels.push_back(want);
		end
	endtask

	// never let an emit read a store entry that holds nothing yet
	task automatic emit_next(input bit typed, input logic [PIX_W-1:0] t_pix,
		input logic t_fe, input logic t_oor);
		longint unsigned a;
		a = source_address();
		if (a < STORE_DEPTH_DEF && !src_store.exists(a))
			send_request(CMD_LOAD, a[LA_W-1:0], $urandom, 1'b0, '0, 1'b0, 1'b0);
		send_request(CMD_EMIT, LA_W'($urandom), $urandom, typed, t_pix, t_fe, t_oor);
	endtask

	task automatic sender_gap();
		int unsigned g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained(input int unsigned settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: pixel %h at (%0d,%0d) with nothing outstanding",
					$time, pixel, out_x, out_y);
				mismatches++;
			end else begin
				head_pixel = pending_pixels.pop_front();
				compare_field("pixel", head_pixel.pixel, pixel);
				compare_field("out_x", head_pixel.x, out_x);
				compare_field("out_y", head_pixel.y, out_y);
				compare_field("frame_end", head_pixel.frame_end, frame_end);
				compare_field("out_of_range", head_pixel.oor, out_of_range);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// result side: random stalls, long ready stretches, one long hold-off on demand
	initial begin
		int unsigned gap;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) :
					$urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		int unsigned sw, sh, ss, dw, dh, n, phase_no;
		bit quiet, calm;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		quiet = 1'b1;
		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					if (!quiet)
						wait_drained(SETTLE_CYCLES);
					quiet = 1'b1;
					write_reg(plan[i].where[CFG_IDX_W-1:0], plan[i].value[CFG_DATA_W-1:0]);
				end
				ROW_LOAD: begin
					send_request(CMD_LOAD, plan[i].where[LA_W-1:0], plan[i].value,
						1'b0, '0, 1'b0, 1'b0);
					quiet = 1'b0;
					sender_gap();
				end
				default: begin
					emit_next(plan[i].typed, plan[i].pix, plan[i].fe, plan[i].oor);
					quiet = 1'b0;
					sender_gap();
				end
			endcase
		end

		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_drained(SETTLE_CYCLES);
			case ($urandom_range(0, 7))
				0: begin
					sw = pick_corner(0, 1, 1024, 2047);
					sh = pick_corner(0, 1, 1024, 2047);
					ss = pick_corner(0, 1, 1024, 2047);
					dw = pick_corner(0, 1, 2048, 4095);
					dh = pick_corner(0, 1, 2048, 4095);
				end
				1: begin
					// tall source with wide pitch: frequent reads past the store
					sw = $urandom_range(1, 64);
					sh = $urandom_range(512, 2047);
					ss = $urandom_range(256, 2047);
					dw = $urandom_range(1, 8);
					dh = $urandom_range(1, 4);
				end
				default: begin
					sw = $urandom_range(1, 16);
					sh = $urandom_range(1, 16);
					ss = $urandom_range(0, 24);
					dw = $urandom_range(1, 12);
					dh = $urandom_range(1, 8);
				end
			endcase
			write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(sw));
			write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
			write_reg(CFG_SRC_STRIDE, CFG_DATA_W'(ss));
			write_reg(CFG_DST_WIDTH, CFG_DATA_W'(dw));
			write_reg(CFG_DST_HEIGHT, CFG_DATA_W'(dh));
			write_reg(CFG_PIXEL_MODE, CFG_DATA_W'($urandom_range(0, 3)));
			phase_no++;

			if (phase_no == 3) begin
				// keep offering emits while the result side holds off
				hold_request = 1'b1;
				repeat (40) emit_next(1'b0, '0, 1'b0, 1'b0);
				wait_drained(0);
			end else begin
				calm = ($urandom_range(0, 3) == 0);
				n = $urandom_range(8, 60);
				repeat (n) begin
					if ($urandom_range(0, 9) < 7)
						emit_next(1'b0, '0, 1'b0, 1'b0);
					else
						send_request(CMD_LOAD,
							LA_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 4095)),
							$urandom, 1'b0, '0, 1'b0, 1'b0);
					if (!calm)
						sender_gap();
					if ($urandom_range(0, 39) == 0)
						wait_drained(0);
				end
			end
		end

		wait_drained(SETTLE_CYCLES);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
sv/nnsc_pkg.sv
sv/nearest_neighbor_scaler_pixel_convert_top.sv
sv/nnsc_checker.sv
bench/tb_top.sv
